>>> src/bba_pkg.sv
// bba_pkg: shared types, codes and default sizes for the buddy block allocator
// used by buddy_block_allocator; depends on nothing else
`default_nettype none
package bba_pkg;

    localparam int PAGES_DEF           = 4096;
    localparam int ORDERS_DEF          = 9;
    localparam int MIN_BLOCK_BYTES_DEF = 65536;

    localparam int ADDR_W  = 48;
    localparam int SIZE_W  = 25;
    localparam int BLKS_W  = 5;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_TOOLARGE = 2'd2;
    localparam logic [1:0] ST_BADFREE  = 2'd3;

    localparam logic CFG_REGION_BASE   = 1'b0;
    localparam logic CFG_REGION_BLOCKS = 1'b1;

    typedef struct packed {
        logic              action;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] block_address;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        logic [1:0]        status;
    } result_t;

endpackage
`default_nettype wire

>>> src/buddy_block_allocator.sv
// buddy_block_allocator: buddy allocator over a page table held in one memory
// depends on bba_pkg for payload types, status codes and default sizes
`default_nettype none
// One command is taken when start is high and busy is low; at most one result
// follows, shown on result for one cycle with done high (none if a write of
// region_blocks ends the work first), and the receiver cannot stall it. A
// command rejected on its fields alone answers straight from idle; an allocate
// scans the page table in address order (one memory read per block visited),
// keeps the free block of smallest fitting order, lowest address among equals,
// and splits it one level at a time, or answers no space after the scan; a
// free checks the block head, marks it free and then merges it with its free
// buddy one level at a time up to the top order. After reset and after every
// write of region_blocks the block is busy while it rewrites the page table;
// configuration writes are always taken.
module buddy_block_allocator #(
    parameter int PAGES           = bba_pkg::PAGES_DEF,
    parameter int ORDERS          = bba_pkg::ORDERS_DEF,
    parameter int MIN_BLOCK_BYTES = bba_pkg::MIN_BLOCK_BYTES_DEF
) (
    input  wire  logic                      clk,
    input  wire  logic                      rst_n,
    input  wire  logic                      start,
    output logic                            busy,
    input  wire  bba_pkg::cmd_t             cmd,
    output logic                            done,
    output bba_pkg::result_t                result,
    input  wire  logic                      cfg_valid,
    output logic                            cfg_ready,
    input  wire  logic                      cfg_index,
    input  wire  logic [bba_pkg::ADDR_W-1:0] cfg_data
);

    localparam int PG_W       = $clog2(PAGES);
    localparam int LIM_W      = PG_W + 1;
    localparam int ORD_W      = ($clog2(ORDERS) < 1) ? 1 : $clog2(ORDERS);
    localparam int TOP_ORDER  = ORDERS - 1;
    localparam int TOP_PAGES  = 1 << TOP_ORDER;
    localparam int MAX_BLOCKS = PAGES / TOP_PAGES;
    localparam int MIN_SH     = $clog2(MIN_BLOCK_BYTES);
    localparam int TOP_SH     = MIN_SH + TOP_ORDER;
    localparam int AW         = bba_pkg::ADDR_W;
    localparam int PGO_W      = AW - MIN_SH;
    localparam int ENT_W      = ORD_W + 2;
    localparam logic [63:0] TOP_BYTES = 64'(MIN_BLOCK_BYTES) << TOP_ORDER;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_ASCAN = 4'd2;
    localparam logic [3:0] S_ASPLT = 4'd3;
    localparam logic [3:0] S_FCHK0 = 4'd4;
    localparam logic [3:0] S_FCHKB = 4'd5;
    localparam logic [3:0] S_FWLO  = 4'd6;

    logic [ENT_W-1:0] mem [PAGES];
    logic [ENT_W-1:0] rd_data_reg;

    logic [3:0]                   state_reg, state_next;
    logic [PG_W-1:0]              ptr_reg, ptr_next;
    logic [LIM_W-1:0]             scan_reg, scan_next;
    logic [PG_W-1:0]              best_reg, best_next;
    logic [ORD_W-1:0]             best_ord_reg, best_ord_next;
    logic                         found_reg, found_next;
    logic [ORD_W-1:0]             want_reg, want_next;
    logic [ORD_W-1:0]             k_reg, k_next;
    logic [AW-1:0]                base_reg, base_next;
    logic [bba_pkg::BLKS_W-1:0]   blocks_reg, blocks_next;
    logic                         done_reg, done_next;
    bba_pkg::result_t             result_reg, result_next;

    logic                         mem_we;
    logic [PG_W-1:0]              mem_waddr;
    logic [ENT_W-1:0]             mem_wdata;
    logic [PG_W-1:0]              mem_raddr;

    logic [bba_pkg::BLKS_W-1:0]   active;
    logic [LIM_W-1:0]             limit;
    logic [ORD_W-1:0]             want_c;
    logic                         too_large;
    logic [AW-1:0]                off;
    logic [PGO_W-1:0]             off_pg;
    logic                         rd_head, rd_used;
    logic [ORD_W-1:0]             rd_ord;
    logic                         cand;
    logic [LIM_W-1:0]             scan_nx;
    logic                         clr_top;

    assign active = (32'(blocks_reg) > MAX_BLOCKS) ? bba_pkg::BLKS_W'(MAX_BLOCKS)
                                                    : blocks_reg;
    assign limit  = LIM_W'(active) << TOP_ORDER;
    assign too_large = {39'd0, cmd.request_size} > TOP_BYTES;
    assign off    = cmd.block_address - base_reg;
    assign off_pg = off[AW-1:MIN_SH];
    assign rd_head = rd_data_reg[ENT_W-1];
    assign rd_used = rd_data_reg[ENT_W-2];
    assign rd_ord  = rd_data_reg[ORD_W-1:0];
    assign clr_top = (ptr_reg[TOP_ORDER-1:0] == '0)
                  && ((LIM_W'(ptr_reg) >> TOP_ORDER) < LIM_W'(active));

    always_comb
    begin
        want_c = '0;
        for (int k = 0; k < TOP_ORDER; k++)
        begin
            if ((64'(MIN_BLOCK_BYTES) << k) < 64'(cmd.request_size))
            begin
                want_c = ORD_W'(k + 1);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        scan_next     = scan_reg;
        best_next     = best_reg;
        best_ord_next = best_ord_reg;
        found_next    = found_reg;
        want_next     = want_reg;
        k_next        = k_reg;
        base_next     = base_reg;
        blocks_next   = blocks_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        mem_we        = 1'b0;
        mem_waddr     = ptr_reg;
        mem_wdata     = '0;
        mem_raddr     = '0;
        cand          = 1'b0;
        scan_nx       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    result_next.granted_address = '0;
                    result_next.status          = bba_pkg::ST_OK;
                    if (cmd.action == bba_pkg::ACT_ALLOC)
                    begin
                        if (too_large)
                        begin
                            result_next.status = bba_pkg::ST_TOOLARGE;
                            done_next = 1'b1;
                        end
                        else if (limit == '0)
                        begin
                            result_next.status = bba_pkg::ST_NOSPACE;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            mem_raddr  = '0;
                            scan_next  = '0;
                            found_next = 1'b0;
                            want_next  = want_c;
                            state_next = S_ASCAN;
                        end
                    end
                    else
                    begin
                        if ((cmd.block_address < base_reg)
                            || (off[MIN_SH-1:0] != '0)
                            || (off_pg >= PGO_W'(limit)))
                        begin
                            result_next.status = bba_pkg::ST_BADFREE;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            ptr_next   = off_pg[PG_W-1:0];
                            mem_raddr  = off_pg[PG_W-1:0];
                            state_next = S_FCHK0;
                        end
                    end
                end
            end
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = {clr_top, 1'b0, clr_top ? ORD_W'(TOP_ORDER) : ORD_W'(0)};
                if (ptr_reg == PG_W'(PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_ASCAN:
            begin
                cand = rd_head && !rd_used && (rd_ord >= want_reg)
                    && (!found_reg || (rd_ord < best_ord_reg));
                if (cand)
                begin
                    found_next    = 1'b1;
                    best_next     = scan_reg[PG_W-1:0];
                    best_ord_next = rd_ord;
                end
                scan_nx = scan_reg + (rd_head ? (LIM_W'(1) << rd_ord) : LIM_W'(1));
                if (scan_nx >= limit)
                begin
                    if (cand || found_reg)
                    begin
                        k_next     = cand ? rd_ord : best_ord_reg;
                        state_next = S_ASPLT;
                    end
                    else
                    begin
                        result_next.status = bba_pkg::ST_NOSPACE;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    scan_next = scan_nx;
                    mem_raddr = scan_nx[PG_W-1:0];
                end
            end
            S_ASPLT:
            begin
                mem_we = 1'b1;
                if (k_reg > want_reg)
                begin
                    mem_waddr = best_reg + (PG_W'(1) << (k_reg - 1'b1));
                    mem_wdata = {1'b1, 1'b0, k_reg - 1'b1};
                    k_next    = k_reg - 1'b1;
                end
                else
                begin
                    mem_waddr = best_reg;
                    mem_wdata = {1'b1, 1'b1, want_reg};
                    result_next.granted_address = base_reg + (AW'(best_reg) << MIN_SH);
                    result_next.status          = bba_pkg::ST_OK;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FCHK0:
            begin
                if (!rd_head || !rd_used)
                begin
                    result_next.status = bba_pkg::ST_BADFREE;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_reg;
                    mem_wdata = {1'b1, 1'b0, rd_ord};
                    k_next    = rd_ord;
                    if (32'(rd_ord) < TOP_ORDER)
                    begin
                        mem_raddr  = ptr_reg ^ (PG_W'(1) << rd_ord);
                        state_next = S_FCHKB;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_FCHKB:
            begin
                if (rd_head && !rd_used && (rd_ord == k_reg))
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = ptr_reg | (PG_W'(1) << k_reg);
                    mem_wdata  = '0;
                    ptr_next   = ptr_reg & ~(PG_W'(1) << k_reg);
                    state_next = S_FWLO;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FWLO:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = {1'b1, 1'b0, k_reg + 1'b1};
                k_next    = k_reg + 1'b1;
                if (32'(k_reg) + 1 < TOP_ORDER)
                begin
                    mem_raddr  = ptr_reg ^ (PG_W'(1) << (k_reg + 1'b1));
                    state_next = S_FCHKB;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // configuration transfer
        if (cfg_valid)
        begin
            if (cfg_index == bba_pkg::CFG_REGION_BASE)
            begin
                base_next = {cfg_data[AW-1:TOP_SH], TOP_SH'(0)};
            end
            else
            begin
                blocks_next = cfg_data[bba_pkg::BLKS_W-1:0];
                ptr_next    = '0;
                state_next  = S_CLEAR;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            ptr_reg      <= '0;
            found_reg    <= 1'b0;
            base_reg     <= '0;
            blocks_reg   <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            found_reg    <= found_next;
            base_reg     <= base_next;
            blocks_reg   <= blocks_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        best_reg     <= best_next;
        best_ord_reg <= best_ord_next;
        want_reg     <= want_next;
        k_reg        <= k_next;
        result_reg   <= result_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still working");

    a_error_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status != bba_pkg::ST_OK) |-> result.granted_address == '0)
        else $error("nonzero address on error result");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !cfg_valid && !done_next |=> busy)
        else $error("command transfer did not start work");
`endif

endmodule
`default_nettype wire
